// ----- rtl/core/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, compiled out when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checks a property on every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Checks that an expression is never true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

// ----- rtl/core/sha256_pkg.sv -----
// ---------------------------------------------------------------------------
// SHA-256 engine package
// Shared types, command and status structs, and the initial hash and round constant tables.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sha256_pkg;

  localparam logic [5:0] BlockLast = 6'h3F;
  localparam logic [5:0] LenPos    = 6'd56;
  localparam logic [7:0] PadMark   = 8'h80;
  localparam logic [5:0] RoundLast = 6'd63;
  localparam logic [2:0] WordLast  = 3'd7;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_ROUND,
    ST_FOLD,
    ST_PAD_MARK,
    ST_PAD_FILL1,
    ST_PAD_FILL2,
    ST_PAD_LEN,
    ST_EMIT
  } state_e;

  // Source of a byte written into the block buffer.
  typedef enum logic [1:0] {
    BSRC_DATA,
    BSRC_MARK,
    BSRC_ZERO,
    BSRC_LEN
  } bsrc_e;

  typedef struct packed {
    logic  wr_en;
    bsrc_e wr_src;
    logic  comp_start;
    logic  round_en;
    logic  fold;
    logic  out_next;
    logic  reinit;
  } cmd_t;

  typedef struct packed {
    logic [5:0] count_lo;
    logic [5:0] pad_pos;
    logic       round_last;
    logic       out_last;
  } status_t;

  function automatic logic [31:0] init_hash(input logic [2:0] idx);
    logic [31:0] v;
    case (idx)
      3'd0:    v = 32'h6A09E667;
      3'd1:    v = 32'hBB67AE85;
      3'd2:    v = 32'h3C6EF372;
      3'd3:    v = 32'hA54FF53A;
      3'd4:    v = 32'h510E527F;
      3'd5:    v = 32'h9B05688C;
      3'd6:    v = 32'h1F83D9AB;
      3'd7:    v = 32'h5BE0CD19;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] round_const(input logic [5:0] idx);
    logic [31:0] k;
    case (idx)
      6'd0:  k = 32'h428A2F98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hB5C0FBCF;  6'd3:  k = 32'hE9B5DBA5;
      6'd4:  k = 32'h3956C25B;  6'd5:  k = 32'h59F111F1;
      6'd6:  k = 32'h923F82A4;  6'd7:  k = 32'hAB1C5ED5;
      6'd8:  k = 32'hD807AA98;  6'd9:  k = 32'h12835B01;
      6'd10: k = 32'h243185BE;  6'd11: k = 32'h550C7DC3;
      6'd12: k = 32'h72BE5D74;  6'd13: k = 32'h80DEB1FE;
      6'd14: k = 32'h9BDC06A7;  6'd15: k = 32'hC19BF174;
      6'd16: k = 32'hE49B69C1;  6'd17: k = 32'hEFBE4786;
      6'd18: k = 32'h0FC19DC6;  6'd19: k = 32'h240CA1CC;
      6'd20: k = 32'h2DE92C6F;  6'd21: k = 32'h4A7484AA;
      6'd22: k = 32'h5CB0A9DC;  6'd23: k = 32'h76F988DA;
      6'd24: k = 32'h983E5152;  6'd25: k = 32'hA831C66D;
      6'd26: k = 32'hB00327C8;  6'd27: k = 32'hBF597FC7;
      6'd28: k = 32'hC6E00BF3;  6'd29: k = 32'hD5A79147;
      6'd30: k = 32'h06CA6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27B70A85;  6'd33: k = 32'h2E1B2138;
      6'd34: k = 32'h4D2C6DFC;  6'd35: k = 32'h53380D13;
      6'd36: k = 32'h650A7354;  6'd37: k = 32'h766A0ABB;
      6'd38: k = 32'h81C2C92E;  6'd39: k = 32'h92722C85;
      6'd40: k = 32'hA2BFE8A1;  6'd41: k = 32'hA81A664B;
      6'd42: k = 32'hC24B8B70;  6'd43: k = 32'hC76C51A3;
      6'd44: k = 32'hD192E819;  6'd45: k = 32'hD6990624;
      6'd46: k = 32'hF40E3585;  6'd47: k = 32'h106AA070;
      6'd48: k = 32'h19A4C116;  6'd49: k = 32'h1E376C08;
      6'd50: k = 32'h2748774C;  6'd51: k = 32'h34B0BCB5;
      6'd52: k = 32'h391C0CB3;  6'd53: k = 32'h4ED8AA4A;
      6'd54: k = 32'h5B9CCA4F;  6'd55: k = 32'h682E6FF3;
      6'd56: k = 32'h748F82EE;  6'd57: k = 32'h78A5636F;
      6'd58: k = 32'h84C87814;  6'd59: k = 32'h8CC70208;
      6'd60: k = 32'h90BEFFFA;  6'd61: k = 32'hA4506CEB;
      6'd62: k = 32'hBEF9A3F7;  6'd63: k = 32'hC67178F2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/sha256_hash_engine_unit.sv -----
// ---------------------------------------------------------------------------
// SHA-256 hash engine
// Hashes a byte stream and returns the eight digest words per message.
// ---------------------------------------------------------------------------
//
//   Channel  Direction  Handshake              Beat payload
//   in       input      in_valid_i/in_ready_o   data_byte_i, byte_present_i,
//                                               message_end_i
//   out      output     out_valid_o/out_ready_i digest_word_o, word_number_o,
//                                               final_word_o
//
// A byte beat is written straight into the block buffer; the beat that fills
// a block starts the compression (load, 64 rounds in the single round unit, fold).
// A message end adds one byte of padding per cycle, outside compressions, up to
// the next block end, with an idle step before the length field, plus one or two
// compressions, then eight output beats.
// Input is stalled while the engine compresses, pads or drains the digest.
// Reset restores the initial hash values and clears the byte count.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sha256_hash_engine_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        byte_present_i,
  input  wire logic        message_end_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      digest_word_o,
  output logic [2:0]       word_number_o,
  output logic             final_word_o
);

  sha256_pkg::cmd_t    cmd;
  sha256_pkg::status_t status;

  sha256_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .byte_present_i (byte_present_i),
    .message_end_i  (message_end_i),
    .out_ready_i    (out_ready_i),
    .status_i       (status),
    .in_ready_o     (in_ready_o),
    .out_valid_o    (out_valid_o),
    .cmd_o          (cmd)
  );

  sha256_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .data_byte_i   (data_byte_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .digest_word_o (digest_word_o),
    .word_number_o (word_number_o),
    .final_word_o  (final_word_o)
  );

  // The engine never takes input while a digest is being read out.
  `ASSERT_NEVER(a_no_in_during_out, clk_i, rst_ni, in_ready_o && out_valid_o)

  // Digest words leave in order without gaps.
  `ASSERT_PROP(a_word_order, clk_i, rst_ni, (out_valid_o && out_ready_i && !final_word_o) |=> (out_valid_o && word_number_o == $past(word_number_o) + 3'd1))

  // After the last word the engine is ready for the next message.
  `ASSERT_PROP(a_ready_after_last, clk_i, rst_ni, (out_valid_o && out_ready_i && final_word_o) |=> (in_ready_o && word_number_o == 3'd0))

endmodule

`default_nettype wire

// ----- rtl/core/sha256_datapath.sv -----
// ---------------------------------------------------------------------------
// SHA-256 datapath
// Block buffer and schedule window, working and chaining words, byte count,
// padding pointer, round counter and digest readout.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sha256_datapath (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [7:0]        data_byte_i,
  input  wire sha256_pkg::cmd_t  cmd_i,
  output sha256_pkg::status_t    status_o,
  output logic [31:0]            digest_word_o,
  output logic [2:0]             word_number_o,
  output logic                   final_word_o
);

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // The buffer words double as the schedule window: word 0 is the word of
  // the current round, and each round shifts the next schedule word in.
  logic [31:0] win_q [16];
  logic [31:0] work_q [8];
  logic [31:0] chain_q [8];
  logic [63:0] count_q;
  logic [5:0]  pad_pos_q;
  logic [5:0]  round_q;
  logic [2:0]  out_idx_q;

  logic [5:0]  wr_addr;
  logic [7:0]  wr_byte;
  logic [63:0] len_bits;
  logic [63:0] len_shift;
  logic [31:0] w_new;
  logic [31:0] s0, s1, t1, t2, ch, maj, bs0, bs1;

  assign len_bits  = {count_q[60:0], 3'b000};
  // Length bytes go out most significant first at positions 56 to 63.
  assign len_shift = len_bits >> {~pad_pos_q[2:0], 3'b000};

  always_comb begin
    wr_addr = pad_pos_q;
    wr_byte = 8'h00;
    case (cmd_i.wr_src)
      sha256_pkg::BSRC_DATA: begin
        wr_addr = count_q[5:0];
        wr_byte = data_byte_i;
      end
      sha256_pkg::BSRC_MARK: begin
        wr_addr = count_q[5:0];
        wr_byte = sha256_pkg::PadMark;
      end
      sha256_pkg::BSRC_ZERO: wr_byte = 8'h00;
      sha256_pkg::BSRC_LEN:  wr_byte = len_shift[7:0];
      default:               wr_byte = 8'h00;
    endcase
  end

  always_comb begin
    s0    = rotr(win_q[1], 7) ^ rotr(win_q[1], 18) ^ (win_q[1] >> 3);
    s1    = rotr(win_q[14], 17) ^ rotr(win_q[14], 19) ^ (win_q[14] >> 10);
    w_new = s1 + win_q[9] + s0 + win_q[0];
    bs1   = rotr(work_q[4], 6) ^ rotr(work_q[4], 11) ^ rotr(work_q[4], 25);
    ch    = (work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]);
    bs0   = rotr(work_q[0], 2) ^ rotr(work_q[0], 13) ^ rotr(work_q[0], 22);
    maj   = (work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2]) ^ (work_q[1] & work_q[2]);
    t1    = work_q[7] + bs1 + ch + sha256_pkg::round_const(round_q) + win_q[0];
    t2    = bs0 + maj;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.round_en) begin
      for (int i = 0; i < 15; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[15] <= w_new;
    end else if (cmd_i.wr_en) begin
      win_q[wr_addr[5:2]][{~wr_addr[1:0], 3'b000} +: 8] <= wr_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) begin
        work_q[i]  <= 32'h0;
        chain_q[i] <= sha256_pkg::init_hash(3'(i));
      end
      count_q   <= 64'h0;
      pad_pos_q <= 6'h0;
      round_q   <= 6'h0;
      out_idx_q <= 3'h0;
    end else begin
      if (cmd_i.wr_en) begin
        case (cmd_i.wr_src)
          sha256_pkg::BSRC_DATA: count_q   <= count_q + 64'd1;
          sha256_pkg::BSRC_MARK: pad_pos_q <= count_q[5:0] + 6'd1;
          default:               pad_pos_q <= pad_pos_q + 6'd1;
        endcase
      end
      if (cmd_i.comp_start) begin
        for (int i = 0; i < 8; i++) begin
          work_q[i] <= chain_q[i];
        end
        round_q <= 6'h0;
      end
      if (cmd_i.round_en) begin
        work_q[7] <= work_q[6];
        work_q[6] <= work_q[5];
        work_q[5] <= work_q[4];
        work_q[4] <= work_q[3] + t1;
        work_q[3] <= work_q[2];
        work_q[2] <= work_q[1];
        work_q[1] <= work_q[0];
        work_q[0] <= t1 + t2;
        round_q   <= round_q + 6'd1;
      end
      if (cmd_i.fold) begin
        for (int i = 0; i < 8; i++) begin
          chain_q[i] <= chain_q[i] + work_q[i];
        end
      end
      if (cmd_i.out_next) begin
        out_idx_q <= out_idx_q + 3'd1;
      end
      if (cmd_i.reinit) begin
        for (int i = 0; i < 8; i++) begin
          chain_q[i] <= sha256_pkg::init_hash(3'(i));
        end
        count_q <= 64'h0;
      end
    end
  end

  assign status_o.count_lo   = count_q[5:0];
  assign status_o.pad_pos    = pad_pos_q;
  assign status_o.round_last = (round_q == sha256_pkg::RoundLast);
  assign status_o.out_last   = (out_idx_q == sha256_pkg::WordLast);

  assign digest_word_o = chain_q[out_idx_q];
  assign word_number_o = out_idx_q;
  assign final_word_o  = (out_idx_q == sha256_pkg::WordLast);

endmodule

`default_nettype wire

// ----- rtl/core/sha256_ctrl.sv -----
// ---------------------------------------------------------------------------
// SHA-256 controller
// Sequences byte loads, padding, block compression and digest readout.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sha256_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  input  wire logic                 byte_present_i,
  input  wire logic                 message_end_i,
  input  wire logic                 out_ready_i,
  input  wire sha256_pkg::status_t  status_i,
  output logic                      in_ready_o,
  output logic                      out_valid_o,
  output sha256_pkg::cmd_t          cmd_o
);

  sha256_pkg::state_e state_q, state_d;
  // Where to continue once a compression has been folded into the chain.
  sha256_pkg::state_e after_q, after_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sha256_pkg::ST_IDLE;
      after_q <= sha256_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
      after_q <= after_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    after_d     = after_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    cmd_o.wr_src = sha256_pkg::BSRC_DATA;
    case (state_q)
      sha256_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (byte_present_i) begin
            cmd_o.wr_en  = 1'b1;
            cmd_o.wr_src = sha256_pkg::BSRC_DATA;
          end
          if (byte_present_i && status_i.count_lo == sha256_pkg::BlockLast) begin
            state_d = sha256_pkg::ST_START;
            after_d = message_end_i ? sha256_pkg::ST_PAD_MARK : sha256_pkg::ST_IDLE;
          end else if (message_end_i) begin
            state_d = sha256_pkg::ST_PAD_MARK;
          end
        end
      end
      sha256_pkg::ST_PAD_MARK: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_src = sha256_pkg::BSRC_MARK;
        // No room for the length after the marker: finish this block first.
        if (status_i.count_lo == sha256_pkg::BlockLast) begin
          state_d = sha256_pkg::ST_START;
          after_d = sha256_pkg::ST_PAD_FILL2;
        end else if (status_i.count_lo >= sha256_pkg::LenPos) begin
          state_d = sha256_pkg::ST_PAD_FILL1;
        end else begin
          state_d = sha256_pkg::ST_PAD_FILL2;
        end
      end
      sha256_pkg::ST_PAD_FILL1: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_src = sha256_pkg::BSRC_ZERO;
        if (status_i.pad_pos == sha256_pkg::BlockLast) begin
          state_d = sha256_pkg::ST_START;
          after_d = sha256_pkg::ST_PAD_FILL2;
        end
      end
      sha256_pkg::ST_PAD_FILL2: begin
        if (status_i.pad_pos == sha256_pkg::LenPos) begin
          state_d = sha256_pkg::ST_PAD_LEN;
        end else begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.wr_src = sha256_pkg::BSRC_ZERO;
        end
      end
      sha256_pkg::ST_PAD_LEN: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_src = sha256_pkg::BSRC_LEN;
        if (status_i.pad_pos == sha256_pkg::BlockLast) begin
          state_d = sha256_pkg::ST_START;
          after_d = sha256_pkg::ST_EMIT;
        end
      end
      sha256_pkg::ST_START: begin
        cmd_o.comp_start = 1'b1;
        state_d          = sha256_pkg::ST_ROUND;
      end
      sha256_pkg::ST_ROUND: begin
        cmd_o.round_en = 1'b1;
        if (status_i.round_last) begin
          state_d = sha256_pkg::ST_FOLD;
        end
      end
      sha256_pkg::ST_FOLD: begin
        cmd_o.fold = 1'b1;
        state_d    = after_q;
      end
      sha256_pkg::ST_EMIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          cmd_o.out_next = 1'b1;
          if (status_i.out_last) begin
            cmd_o.reinit = 1'b1;
            state_d      = sha256_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = sha256_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- test/sha256_hash_engine_unit_test.sv -----
// ---------------------------------------------------------------------------
// SHA-256 hash engine unit test
// Feeds byte beats that form whole messages, with ignored beats mixed in, and
// checks every digest word against an in-bench SHA-256 predictor. Both sides
// idle at random; one long output hold-off backs the engine up into its input.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha256_hash_engine_unit_test;

  localparam int LimitCycles   = 200000;
  localparam int DrainCycles   = 150;
  localparam int HoldOffCycles = 400;
  localparam int IdlePct       = 21;
  localparam int ErrorsShown   = 10;
  localparam int BlockBytes    = 64;
  localparam int RandomBeats   = 140;

  localparam logic [64*32-1:0] RoundK = {
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
    32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
    32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
    32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
    32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
    32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
    32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
    32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
    32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
    32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
    32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
  };

  localparam logic [8*32-1:0] HashInit = {
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  typedef struct {
    logic [7:0] data;
    logic       present;
    logic       close;
    logic       hold;     // wait for every pending digest word before offering
  } beat_t;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  num;
    logic        last;
  } digest_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i = 8'h00;
  logic        byte_present_i = 1'b0;
  logic        message_end_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] digest_word_o;
  logic [2:0]  word_number_o;
  logic        final_word_o;

  sha256_hash_engine_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .byte_present_i (byte_present_i),
    .message_end_i  (message_end_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .digest_word_o  (digest_word_o),
    .word_number_o  (word_number_o),
    .final_word_o   (final_word_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  beat_t   pending_beats[$];
  digest_t expected_digest[$];

  // Predictor state.
  logic [31:0] chain_h[8];
  logic [7:0]  blk[BlockBytes];
  logic [63:0] msg_bytes;

  int errors = 0;
  int in_count = 0;
  int ignored_count = 0;
  int messages_done = 0;
  int bytes_done = 0;
  int longest_msg = 0;
  int cycles = 0;
  logic in_beat_done = 1'b0;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void sha_restart();
    for (int i = 0; i < 8; i++) chain_h[i] = HashInit[(7 - i) * 32 +: 32];
    msg_bytes = '0;
  endfunction

  function automatic void sha_compress();
    logic [31:0] w[16];
    logic [31:0] v[8];
    logic [31:0] t1, t2, s0, s1, w2, w15;
    for (int i = 0; i < 8; i++) v[i] = chain_h[i];
    for (int i = 0; i < 16; i++) w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    for (int r = 0; r < 64; r++) begin
      // The schedule lives in a 16-word window that is rewritten in place.
      if (r >= 16) begin
        w2  = w[(r - 2) & 15];
        w15 = w[(r - 15) & 15];
        s1 = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
        s0 = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
        w[r & 15] = s1 + w[(r - 7) & 15] + s0 + w[r & 15];
      end
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25)) +
           ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[(63 - r) * 32 +: 32] + w[r & 15];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22)) +
           ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain_h[i] = chain_h[i] + v[i];
  endfunction

  // Absorbs one accepted beat and queues the digest words a closing beat produces.
  function automatic void sha_absorb(input logic [7:0] d, input logic p, input logic c);
    int pos;
    logic [63:0] bits;
    digest_t dg;
    if (p) begin
      blk[msg_bytes[5:0]] = d;
      msg_bytes = msg_bytes + 64'd1;
      if (msg_bytes[5:0] == 6'd0) sha_compress();
    end
    if (!p && !c) ignored_count++;
    if (c) begin
      pos = int'(msg_bytes[5:0]);
      blk[pos] = sha256_pkg::PadMark;
      pos++;
      // No room left for the length field: pad out and spill into a second block.
      if (pos > int'(sha256_pkg::LenPos)) begin
        while (pos < BlockBytes) begin
          blk[pos] = 8'h00;
          pos++;
        end
        sha_compress();
        pos = 0;
      end
      while (pos < int'(sha256_pkg::LenPos)) begin
        blk[pos] = 8'h00;
        pos++;
      end
      bits = msg_bytes << 3;
      for (int i = 0; i < 8; i++) blk[int'(sha256_pkg::LenPos) + i] = bits[(7 - i) * 8 +: 8];
      sha_compress();
      for (int i = 0; i < 8; i++) begin
        dg.word = chain_h[i];
        dg.num  = 3'(i);
        dg.last = (3'(i) == sha256_pkg::WordLast);
        expected_digest.push_back(dg);
      end
      messages_done++;
      bytes_done += int'(msg_bytes);
      if (int'(msg_bytes) > longest_msg) longest_msg = int'(msg_bytes);
      sha_restart();
    end
  endfunction

  task automatic flag_error(input string msg);
    errors++;
    if (errors <= ErrorsShown) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  function automatic logic quiet_window();
    return in_count >= 100 && in_count < 150;
  endfunction

  // Output checks first, then the input beat is folded into the predictor.
  always @(posedge clk_i) begin
    digest_t exp_dg;
    cycles++;
    if (cycles == LimitCycles) begin
      $display("Timeout after %0d cycles, %0d digest words still pending.",
               cycles, expected_digest.size());
      $display("sha256_hash_engine_unit verification failed");
      $finish;
    end
    in_beat_done <= in_valid_i && in_ready_o;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_digest.size() == 0) begin
        flag_error($sformatf("unexpected digest beat word=%08h num=%0d last=%0b",
                             digest_word_o, word_number_o, final_word_o));
      end else begin
        exp_dg = expected_digest.pop_front();
        if (digest_word_o !== exp_dg.word || word_number_o !== exp_dg.num ||
            final_word_o !== exp_dg.last) begin
          flag_error($sformatf("digest exp word=%08h num=%0d last=%0b got %08h/%0d/%0b",
                               exp_dg.word, exp_dg.num, exp_dg.last,
                               digest_word_o, word_number_o, final_word_o));
        end
      end
    end
    if (rst_ni && in_valid_i && in_ready_o) begin
      sha_absorb(data_byte_i, byte_present_i, message_end_i);
      in_count++;
    end
  end

  // Input driver: at most one assignment to each signal per falling edge.
  always @(negedge clk_i) begin
    beat_t b;
    if (rst_ni && (!in_valid_i || in_beat_done)) begin
      if (pending_beats.size() == 0 ||
          (pending_beats[0].hold && expected_digest.size() != 0) ||
          (!quiet_window() && $urandom_range(0, 99) < IdlePct)) begin
        in_valid_i <= 1'b0;
      end else begin
        b = pending_beats.pop_front();
        in_valid_i     <= 1'b1;
        data_byte_i    <= b.data;
        byte_present_i <= b.present;
        message_end_i  <= b.close;
      end
    end
  end

  // Output ready: random stalls plus one long hold-off once a digest is waiting after at least 40 accepted beats.
  int  hold_left = 0;
  logic hold_done = 1'b0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (!hold_done && out_valid_o && in_count >= 40) begin
        hold_done = 1'b1;
        hold_left = HoldOffCycles;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= quiet_window() || ($urandom_range(0, 99) >= IdlePct);
      end
    end
  end

  task automatic queue_beat(input logic [7:0] d, input logic p, input logic c,
                            input logic h);
    beat_t b;
    b.data = d;
    b.present = p;
    b.close = c;
    b.hold = h;
    pending_beats.push_back(b);
  endtask

  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  // A message of len bytes, closed either on its last byte or by a bare end beat.
  task automatic queue_message(input int len, input logic hold_first, output int counted);
    logic joined;
    logic h;
    int extra;
    joined = (len > 0) && ($urandom_range(0, 1) == 1);
    h = hold_first;
    extra = 0;
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(0, 9) == 0) begin
        queue_beat(pick_byte(), 1'b0, 1'b0, h);
        h = 1'b0;
        extra++;
      end
      queue_beat(pick_byte(), 1'b1, joined && (k == len - 1), h);
      h = 1'b0;
    end
    if (!joined) queue_beat(pick_byte(), 1'b0, 1'b1, h);
    counted = len + extra + (joined ? 0 : 1);
  endtask

  initial begin
    int total;
    int n;
    int len;
    int edge_pick;
    logic paused;
    int edge_lens[4];
    edge_lens = '{56, 55, 64, 63};
    sha_restart();
    for (int i = 0; i < BlockBytes; i++) blk[i] = 8'h00;

    // Directed: empty message, ignored beats, "abc", extreme bytes, byte with end.
    queue_beat(8'h00, 1'b0, 1'b1, 1'b0);
    queue_beat(8'hFF, 1'b0, 1'b0, 1'b0);
    queue_beat(8'h61, 1'b1, 1'b0, 1'b0);
    queue_beat(8'h62, 1'b1, 1'b0, 1'b0);
    queue_beat(8'h63, 1'b1, 1'b1, 1'b0);
    queue_beat(8'h00, 1'b1, 1'b0, 1'b0);
    queue_beat(8'hFF, 1'b1, 1'b0, 1'b0);
    queue_beat(8'h5A, 1'b0, 1'b1, 1'b0);
    queue_beat(8'hFF, 1'b1, 1'b1, 1'b0);
    queue_beat(8'hA5, 1'b0, 1'b1, 1'b0);
    queue_beat(8'h00, 1'b0, 1'b0, 1'b0);
    queue_beat(8'h80, 1'b1, 1'b1, 1'b0);

    // Random messages: mostly short, some around the padding and block edges.
    total = 0;
    edge_pick = 0;
    paused = 1'b0;
    while (total < RandomBeats) begin
      if ($urandom_range(0, 9) == 0) begin
        queue_beat(pick_byte(), 1'b0, 1'b0, 1'b0);
        total++;
      end
      if ($urandom_range(0, 3) == 0) begin
        len = edge_lens[edge_pick % 4];
        edge_pick++;
      end else begin
        len = $urandom_range(0, 9);
      end
      queue_message(len, (total == 0) || (!paused && total >= 80), n);
      if (total >= 80) paused = 1'b1;
      total += n;
    end

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_beats.size() != 0 || in_valid_i || expected_digest.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Accepted %0d beats (%0d ignored), hashed %0d messages of %0d bytes in all,",
             in_count, ignored_count, messages_done, bytes_done);
    $display("longest message %0d bytes, with random idles and one long output hold-off.",
             longest_msg);
    if (errors == 0) begin
      $display("sha256_hash_engine_unit verification clean");
    end else begin
      $display("%0d errors in total.", errors);
      $display("sha256_hash_engine_unit verification failed");
    end
    $finish;
  end

endmodule
